/* rtl/satv_pkg.sv */
// satv_pkg: shared types and constants of the stale-aware triple voter
// no dependencies; used by the channel interfaces and the voter core

package satv_pkg;

  // default widths of a stored reading and of a channel age
  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned DefAgeWidth   = 32;

  // redundant channels and fixed register widths
  localparam int unsigned NumChan      = 3;
  localparam int unsigned TimeoutWidth = 32;
  localparam int unsigned TolWidth     = 31;
  localparam int unsigned RegIdxWidth  = 3;

  // item commands
  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdWrite = 2'd1,
    CmdVote  = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  // channel codes
  localparam logic [1:0] ChanA = 2'd0;
  localparam logic [1:0] ChanB = 2'd1;
  localparam logic [1:0] ChanC = 2'd2;

  // configuration register indexes
  typedef logic [RegIdxWidth-1:0] reg_idx_t;

  localparam reg_idx_t RegTolerance = 3'd0;
  localparam reg_idx_t RegUseLow    = 3'd1;
  localparam reg_idx_t RegTimeoutA  = 3'd2;
  localparam reg_idx_t RegTimeoutB  = 3'd3;
  localparam reg_idx_t RegTimeoutC  = 3'd4;
  localparam reg_idx_t RegSafeA     = 3'd5;
  localparam reg_idx_t RegSafeB     = 3'd6;
  localparam reg_idx_t RegSafeC     = 3'd7;

  // divide by three through a reciprocal: exact for any 32-bit numerator
  localparam int unsigned          DivWidth    = 32;
  localparam logic [DivWidth-1:0]  RecipThree  = 32'hAAAA_AAAB;
  localparam int unsigned          RecipShift  = 33;
  localparam int unsigned          QuoWidth    = 2 * DivWidth - RecipShift;

endpackage

/* rtl/satv_if.sv */
// satv_in_if / satv_out_if: valid-ready channels of the triple voter
// depends on satv_pkg for the default reading width

// command items into the voter
interface satv_in_if #(
  parameter int unsigned VALUE_WIDTH = satv_pkg::DefValueWidth
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [1:0]                    channel;
  logic signed [VALUE_WIDTH-1:0] sample_value;

  modport source (output valid, cmd, channel, sample_value, input ready);
  modport sink   (input valid, cmd, channel, sample_value, output ready);
endinterface

// result items out of the voter
interface satv_out_if #(
  parameter int unsigned VALUE_WIDTH = satv_pkg::DefValueWidth
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic [1:0]                    live_count;
  logic                          safe_used;

  modport source (output valid, result_value, live_count, safe_used, input ready);
  modport sink   (input valid, result_value, live_count, safe_used, output ready);
endinterface

/* rtl/stale_aware_triple_voter_core.sv */
// stale_aware_triple_voter_core: three-channel voter with per-channel freshness
// depends on satv_pkg and the satv_in_if / satv_out_if channel interfaces
//
//   port       direction  handshake            payload
//   sample_i   in         valid / ready        cmd, channel, sample_value
//   result_o   out        valid / ready        result_value, live_count, safe_used
//   apb        in         psel/penable/pready  paddr, pwdata, prdata
//
// One item is taken per cycle while no vote or read is held in the input register.
// Ticks and writes change the channel state at the edge after they are taken; a vote
// or read reaches result_o through an input register, five work stages and the
// output register. Each stage holds its item only while the stage after it is full,
// so a waiting result stops only the items that need a slot behind it.
// Reset clears configuration, stored readings, ages and all valid bits.

module stale_aware_triple_voter_core #(
  parameter int unsigned VALUE_WIDTH = satv_pkg::DefValueWidth,
  parameter int unsigned AGE_WIDTH   = satv_pkg::DefAgeWidth,
  localparam int unsigned PDATA_W    = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int unsigned PADDR_W    = satv_pkg::RegIdxWidth + ((VALUE_WIDTH > 32) ? 3 : 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  satv_in_if.sink            sample_i,
  satv_out_if.source         result_o
);

  import satv_pkg::*;

  localparam int unsigned CmpW    = (AGE_WIDTH > TimeoutWidth) ? AGE_WIDTH : TimeoutWidth;
  localparam int unsigned TolCmpW = (VALUE_WIDTH > TolWidth) ? VALUE_WIDTH : TolWidth;
  localparam int unsigned LastStg = 6;

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [AGE_WIDTH-1:0]   age_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] channel;
    val_t       sample;
  } in_t;

  typedef struct packed {
    val_t       d0;
    val_t       d1;
    val_t       d2;
    logic [1:0] n;
    logic       safe;
  } cand_t;

  typedef struct packed {
    val_t       lo;
    val_t       mid;
    val_t       hi;
    logic [1:0] n;
    logic       safe;
  } srt_t;

  typedef struct packed {
    val_t       lo;
    val_t       mid;
    val_t       hi;
    val_t       dlm;
    val_t       dmh;
    val_t       dlh;
    logic [1:0] n;
    logic       safe;
  } dif_t;

  typedef struct packed {
    val_t                base;
    val_t                add;
    logic [DivWidth-1:0] num;
    logic                mean3;
    logic [1:0]          n;
    logic                safe;
  } dec_t;

  typedef struct packed {
    val_t                base;
    val_t                add;
    logic [QuoWidth-1:0] quo;
    logic                mean3;
    logic [1:0]          n;
    logic                safe;
  } mul_t;

  typedef struct packed {
    val_t       value;
    logic [1:0] n;
    logic       safe;
  } res_t;

  // configuration registers
  logic [TolWidth-1:0]     tol_q;
  logic                    use_low_q;
  logic [TimeoutWidth-1:0] timeout_q [NumChan];
  val_t                    safe_q [NumChan];

  // channel state
  val_t value_q [NumChan];
  age_t age_q [NumChan];

  // pipeline valids, stage 0 is the input register, the last the output register
  logic [LastStg:0] vld_q;
  logic [LastStg:0] vld_d;
  logic [LastStg:1] stg_free;

  in_t   in_q;
  cand_t cand_q;
  cand_t cand_d;
  srt_t  srt_q;
  srt_t  srt_d;
  dif_t  dif_q;
  dif_t  dif_d;
  dec_t  dec_q;
  dec_t  dec_d;
  mul_t  mul_q;
  logic [2*DivWidth-1:0] prod;
  res_t  res_q;
  res_t  res_d;

  logic                   cfg_wr;
  reg_idx_t               cfg_idx;
  logic [NumChan-1:0]     live;
  logic [NumChan-1:0]     fresh;
  val_t                   rd_val [NumChan];
  cmd_e                   in_cmd;
  logic                   chan_ok;
  logic                   has_res;
  logic                   s0_done;
  logic                   in_rdy;

  // apb register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1 -: RegIdxWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= '0;
      use_low_q <= 1'b0;
      for (int i = 0; i < NumChan; i++) begin
        timeout_q[i] <= '0;
        safe_q[i]    <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegTolerance: tol_q              <= pwdata[TolWidth-1:0];
        RegUseLow:    use_low_q          <= pwdata[0];
        RegTimeoutA:  timeout_q[ChanA]   <= pwdata[TimeoutWidth-1:0];
        RegTimeoutB:  timeout_q[ChanB]   <= pwdata[TimeoutWidth-1:0];
        RegTimeoutC:  timeout_q[ChanC]   <= pwdata[TimeoutWidth-1:0];
        RegSafeA:     safe_q[ChanA]      <= pwdata[VALUE_WIDTH-1:0];
        RegSafeB:     safe_q[ChanB]      <= pwdata[VALUE_WIDTH-1:0];
        RegSafeC:     safe_q[ChanC]      <= pwdata[VALUE_WIDTH-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      RegTolerance: prdata = PDATA_W'(tol_q);
      RegUseLow:    prdata = PDATA_W'(use_low_q);
      RegTimeoutA:  prdata = PDATA_W'(timeout_q[ChanA]);
      RegTimeoutB:  prdata = PDATA_W'(timeout_q[ChanB]);
      RegTimeoutC:  prdata = PDATA_W'(timeout_q[ChanC]);
      RegSafeA:     prdata = PDATA_W'(safe_q[ChanA]);
      RegSafeB:     prdata = PDATA_W'(safe_q[ChanB]);
      RegSafeC:     prdata = PDATA_W'(safe_q[ChanC]);
    endcase
  end

  // handshake: each stage takes a new item when it is empty or emptying
  always_comb begin
    stg_free[LastStg] = !vld_q[LastStg] || result_o.ready;
    for (int k = LastStg - 1; k >= 1; k--) begin
      stg_free[k] = !vld_q[k] || stg_free[k+1];
    end
  end

  assign in_cmd  = cmd_e'(in_q.cmd);
  assign chan_ok = in_q.channel < 2'(NumChan);
  assign has_res = (in_cmd == CmdVote) || ((in_cmd == CmdRead) && chan_ok);
  assign s0_done = vld_q[0] && (!has_res || stg_free[1]);
  assign in_rdy  = !vld_q[0] || s0_done;

  assign sample_i.ready = in_rdy;

  always_comb begin
    vld_d[0] = in_rdy ? sample_i.valid : vld_q[0];
    vld_d[1] = stg_free[1] ? (vld_q[0] && has_res) : vld_q[1];
    for (int k = 2; k <= LastStg; k++) begin
      vld_d[k] = stg_free[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_rdy) begin
      in_q.cmd     <= sample_i.cmd;
      in_q.channel <= sample_i.channel;
      in_q.sample  <= sample_i.sample_value;
    end
  end

  // channel state: ticks age every channel, a write stores and restarts the age
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        value_q[i] <= '0;
        age_q[i]   <= '0;
      end
    end else if (s0_done) begin
      if (in_cmd == CmdTick) begin
        for (int i = 0; i < NumChan; i++) begin
          if (age_q[i] != '1) begin
            age_q[i] <= age_q[i] + age_t'(1);
          end
        end
      end else if ((in_cmd == CmdWrite) && chan_ok) begin
        value_q[in_q.channel] <= in_q.sample;
        age_q[in_q.channel]   <= '0;
      end
    end
  end

  // freshness per channel: live up to the timeout, stored value below it
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      live[i]   = CmpW'(age_q[i]) <= CmpW'(timeout_q[i]);
      fresh[i]  = CmpW'(age_q[i]) <  CmpW'(timeout_q[i]);
      rd_val[i] = fresh[i] ? value_q[i] : safe_q[i];
    end
  end

  // stage 1: gather the live read values, or the single read value
  always_comb begin
    cand_d = '0;
    if (in_cmd == CmdVote) begin
      cand_d.n    = 2'($countones(live));
      cand_d.safe = (live == '0);
      case (live)
        3'b000: cand_d.d0 = rd_val[ChanA];
        3'b001: cand_d.d0 = rd_val[ChanA];
        3'b010: cand_d.d0 = rd_val[ChanB];
        3'b100: cand_d.d0 = rd_val[ChanC];
        3'b011: begin
          cand_d.d0 = rd_val[ChanA];
          cand_d.d1 = rd_val[ChanB];
        end
        3'b101: begin
          cand_d.d0 = rd_val[ChanA];
          cand_d.d1 = rd_val[ChanC];
        end
        3'b110: begin
          cand_d.d0 = rd_val[ChanB];
          cand_d.d1 = rd_val[ChanC];
        end
        default: begin
          cand_d.d0 = rd_val[ChanA];
          cand_d.d1 = rd_val[ChanB];
          cand_d.d2 = rd_val[ChanC];
        end
      endcase
    end else begin
      // a read leaves with no live count, as a plain pass value
      case (in_q.channel)
        ChanB: begin
          cand_d.d0   = rd_val[ChanB];
          cand_d.safe = !fresh[ChanB];
        end
        ChanC: begin
          cand_d.d0   = rd_val[ChanC];
          cand_d.safe = !fresh[ChanC];
        end
        default: begin
          cand_d.d0   = rd_val[ChanA];
          cand_d.safe = !fresh[ChanA];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_free[1]) begin
      cand_q <= cand_d;
    end
  end

  // stage 2: sort, ties ordered by position
  always_comb begin
    logic c01;
    logic c02;
    logic c12;
    c01 = $signed(cand_q.d0) > $signed(cand_q.d1);
    c02 = $signed(cand_q.d0) > $signed(cand_q.d2);
    c12 = $signed(cand_q.d1) > $signed(cand_q.d2);
    srt_d.n    = cand_q.n;
    srt_d.safe = cand_q.safe;
    srt_d.lo   = cand_q.d0;
    srt_d.mid  = cand_q.d0;
    srt_d.hi   = cand_q.d0;
    if (cand_q.n == 2'(NumChan)) begin
      srt_d.lo  = (!c01 && !c02) ? cand_q.d0 : (c01 && !c12) ? cand_q.d1 : cand_q.d2;
      srt_d.hi  = (c01 && c02) ? cand_q.d0 : (!c01 && c12) ? cand_q.d1 : cand_q.d2;
      srt_d.mid = (c01 != c02) ? cand_q.d0 : (c01 == c12) ? cand_q.d1 : cand_q.d2;
    end else if (cand_q.n == 2'(NumChan - 1)) begin
      srt_d.lo = c01 ? cand_q.d1 : cand_q.d0;
      srt_d.hi = c01 ? cand_q.d0 : cand_q.d1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_free[2]) begin
      srt_q <= srt_d;
    end
  end

  // stage 3: spreads between sorted values, never negative
  always_comb begin
    dif_d.lo   = srt_q.lo;
    dif_d.mid  = srt_q.mid;
    dif_d.hi   = srt_q.hi;
    dif_d.dlm  = srt_q.mid - srt_q.lo;
    dif_d.dmh  = srt_q.hi - srt_q.mid;
    dif_d.dlh  = srt_q.hi - srt_q.lo;
    dif_d.n    = srt_q.n;
    dif_d.safe = srt_q.safe;
  end

  always_ff @(posedge clk_i) begin
    if (stg_free[3]) begin
      dif_q <= dif_d;
    end
  end

  // stage 4: pick the vote rule; pair means as base plus a rounded-up offset
  always_comb begin
    logic ok_lh;
    logic ok_lm;
    logic ok_mh;
    val_t half_lm;
    val_t half_mh;
    ok_lh   = TolCmpW'(dif_q.dlh) <= TolCmpW'(tol_q);
    ok_lm   = TolCmpW'(dif_q.dlm) <= TolCmpW'(tol_q);
    ok_mh   = TolCmpW'(dif_q.dmh) <= TolCmpW'(tol_q);
    half_lm = (dif_q.dlm >> 1) + val_t'(dif_q.dlm[0]);
    half_mh = (dif_q.dmh >> 1) + val_t'(dif_q.dmh[0]);

    dec_d.n     = dif_q.n;
    dec_d.safe  = dif_q.safe;
    dec_d.num   = DivWidth'(dif_q.dlm) + DivWidth'(dif_q.dlh) + DivWidth'(1);
    dec_d.mean3 = 1'b0;
    dec_d.base  = dif_q.lo;
    dec_d.add   = '0;
    if (dif_q.n == 2'(NumChan)) begin
      if (ok_lh) begin
        dec_d.mean3 = 1'b1;
      end else if (use_low_q && ok_lm) begin
        dec_d.add = half_lm;
      end else if (!use_low_q && ok_mh) begin
        dec_d.base = dif_q.mid;
        dec_d.add  = half_mh;
      end else if (ok_lm) begin
        dec_d.add = half_lm;
      end else if (ok_mh) begin
        dec_d.base = dif_q.mid;
        dec_d.add  = half_mh;
      end else if (!use_low_q) begin
        dec_d.base = dif_q.mid;
      end
    end else if (dif_q.n == 2'(NumChan - 1)) begin
      dec_d.base = use_low_q ? dif_q.lo : dif_q.hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_free[4]) begin
      dec_q <= dec_d;
    end
  end

  // stage 5: divide the three-way spread sum by three
  assign prod = (2*DivWidth)'(dec_q.num) * (2*DivWidth)'(RecipThree);

  always_ff @(posedge clk_i) begin
    if (stg_free[5]) begin
      mul_q.base  <= dec_q.base;
      mul_q.add   <= dec_q.add;
      mul_q.quo   <= prod[2*DivWidth-1:RecipShift];
      mul_q.mean3 <= dec_q.mean3;
      mul_q.n     <= dec_q.n;
      mul_q.safe  <= dec_q.safe;
    end
  end

  // stage 6: final sum into the output register
  always_comb begin
    res_d.value = mul_q.base + (mul_q.mean3 ? val_t'(mul_q.quo) : mul_q.add);
    res_d.n     = mul_q.n;
    res_d.safe  = mul_q.safe;
  end

  always_ff @(posedge clk_i) begin
    if (stg_free[LastStg]) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = vld_q[LastStg];
  assign result_o.result_value = res_q.value;
  assign result_o.live_count   = res_q.n;
  assign result_o.safe_used    = res_q.safe;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for stale_aware_triple_voter_core, predicts every vote and read
// depends on satv_pkg and the satv_in_if / satv_out_if interfaces of the rtl

module tb;
  import satv_pkg::*;

  localparam int unsigned VW            = DefValueWidth;
  localparam int unsigned AW            = DefAgeWidth;
  localparam int unsigned PAW           = RegIdxWidth + 2;
  localparam int unsigned LatencyCycles = 6;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned RxHoldCycles  = 300;

  // out-of-range channel code, ignored by the block
  localparam logic [1:0] ChanNone = 2'd3;

  typedef logic signed [VW-1:0] value_t;

  typedef struct {
    cmd_e       cmd;
    logic [1:0] channel;
    value_t     sample;
  } voter_item_t;

  typedef struct {
    value_t     value;
    logic [1:0] live;
    logic       safe;
  } voter_result_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [PAW-1:0] paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  satv_in_if  #(.VALUE_WIDTH(VW)) sample_if ();
  satv_out_if #(.VALUE_WIDTH(VW)) result_if ();

  stale_aware_triple_voter_core #(
    .VALUE_WIDTH(VW),
    .AGE_WIDTH  (AW)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample_i(sample_if),
    .result_o(result_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted channel state and configuration
  value_t               ch_value [NumChan] = '{default: '0};
  logic [AW-1:0]        ch_age [NumChan]   = '{default: '0};
  logic [TolWidth-1:0]  cfg_tol;
  logic                 cfg_use_low;
  logic [TimeoutWidth-1:0] cfg_timeout [NumChan];
  value_t               cfg_safe [NumChan];

  voter_item_t   item_backlog[$];
  voter_result_t awaited_results[$];
  voter_item_t   cur_item;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;
  logic        rx_hold_req  = 1'b0;
  int unsigned mismatch_count = 0;

  // value of one channel as seen by a read, stale flags the safe value
  function automatic value_t chan_reading(int c, output logic stale);
    stale = !(ch_age[c] < cfg_timeout[c]);
    return stale ? cfg_safe[c] : ch_value[c];
  endfunction

  // rounded mean of two sorted readings, ties go up
  function automatic longint pair_mean(longint lo, longint hi);
    return lo + (hi - lo + 1) / 2;
  endfunction

  // voted value over the live channels, n returns how many were live
  function automatic value_t vote_value(output int n);
    longint v [3];
    longint t;
    longint tol;
    logic   stale;
    n   = 0;
    tol = longint'(cfg_tol);
    for (int c = 0; c < NumChan; c++) begin
      if (ch_age[c] <= cfg_timeout[c]) begin
        v[n] = chan_reading(c, stale);
        n++;
      end
    end
    if (n == 0) return chan_reading(0, stale);
    if (n == 1) return value_t'(v[0]);
    if (v[0] > v[1]) begin
      t = v[0]; v[0] = v[1]; v[1] = t;
    end
    if (n == 2) return value_t'(cfg_use_low ? v[0] : v[1]);
    if (v[1] > v[2]) begin
      t = v[1]; v[1] = v[2]; v[2] = t;
    end
    if (v[0] > v[1]) begin
      t = v[0]; v[0] = v[1]; v[1] = t;
    end
    // full agreement, then the preferred pair, then the other pair
    if (v[2] - v[0] <= tol) return value_t'(v[0] + (v[1] - v[0] + v[2] - v[0] + 1) / 3);
    if (cfg_use_low && v[1] - v[0] <= tol) return value_t'(pair_mean(v[0], v[1]));
    if (!cfg_use_low && v[2] - v[1] <= tol) return value_t'(pair_mean(v[1], v[2]));
    if (v[1] - v[0] <= tol) return value_t'(pair_mean(v[0], v[1]));
    if (v[2] - v[1] <= tol) return value_t'(pair_mean(v[1], v[2]));
    return value_t'(cfg_use_low ? v[0] : v[1]);
  endfunction

  // apply one accepted item to the channel state, queue its result if any
  function automatic void step_voter(voter_item_t it);
    voter_result_t res;
    logic          stale;
    int            n;
    res.live = '0;
    res.safe = 1'b0;
    case (it.cmd)
      CmdTick: begin
        for (int c = 0; c < NumChan; c++) begin
          if (ch_age[c] != '1) ch_age[c] = ch_age[c] + AW'(1);
        end
      end
      CmdWrite: begin
        if (it.channel <= ChanC) begin
          ch_value[it.channel] = it.sample;
          ch_age[it.channel]   = '0;
        end
      end
      CmdVote: begin
        res.value = vote_value(n);
        res.live  = 2'(n);
        res.safe  = (n == 0);
        awaited_results.push_back(res);
      end
      default: begin
        if (it.channel <= ChanC) begin
          res.value = chan_reading(int'(it.channel), stale);
          res.safe  = stale;
          awaited_results.push_back(res);
        end
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
  endfunction

  // item driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid        <= 1'b0;
      sample_if.cmd          <= CmdTick;
      sample_if.channel      <= ChanA;
      sample_if.sample_value <= '0;
    end else begin
      if (sample_if.valid && sample_if.ready) step_voter(cur_item);
      if (!sample_if.valid || sample_if.ready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_item               = item_backlog.pop_front();
          sample_if.valid        <= 1'b1;
          sample_if.cmd          <= cur_item.cmd;
          sample_if.channel      <= cur_item.channel;
          sample_if.sample_value <= cur_item.sample;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each accepted item against the oldest prediction
  always @(posedge clk_i) begin : result_mon
    voter_result_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result, value", 0, result_if.result_value);
        end else begin
          want = awaited_results.pop_front();
          if (result_if.result_value !== want.value)
            flag_mismatch("result_value", want.value, result_if.result_value);
          if (result_if.live_count !== want.live)
            flag_mismatch("live_count", want.live, result_if.live_count);
          if (result_if.safe_used !== want.safe)
            flag_mismatch("safe_used", want.safe, result_if.safe_used);
        end
      end
      result_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off, counted here while the sender keeps going
  initial begin : rx_hold_ctl
    int unsigned left;
    wait (rx_hold_req);
    @(negedge clk_i);
    rx_hold = 1'b1;
    for (left = RxHoldCycles; left > 0; left--) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  // register write: setup cycle, then access until pready
  task automatic apb_write(reg_idx_t idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegTolerance: cfg_tol        = data[TolWidth-1:0];
      RegUseLow:    cfg_use_low    = data[0];
      RegTimeoutA:  cfg_timeout[0] = data;
      RegTimeoutB:  cfg_timeout[1] = data;
      RegTimeoutC:  cfg_timeout[2] = data;
      RegSafeA:     cfg_safe[0]    = value_t'(data);
      RegSafeB:     cfg_safe[1]    = value_t'(data);
      default:      cfg_safe[2]    = value_t'(data);
    endcase
  endtask

  task automatic set_config(logic [31:0] tol, logic use_low, logic [31:0] to_a,
                            logic [31:0] to_b, logic [31:0] to_c, value_t sa,
                            value_t sb, value_t sc);
    apb_write(RegTolerance, tol);
    apb_write(RegUseLow, {31'd0, use_low});
    apb_write(RegTimeoutA, to_a);
    apb_write(RegTimeoutB, to_b);
    apb_write(RegTimeoutC, to_c);
    apb_write(RegSafeA, sa);
    apb_write(RegSafeB, sb);
    apb_write(RegSafeC, sc);
  endtask

  // wait until every item is taken and every result is back, then let the pipe settle
  task automatic drain();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || sample_if.valid || awaited_results.size() != 0);
    repeat (LatencyCycles + 4) @(negedge clk_i);
  endtask

  function automatic void push_item(cmd_e cmd, logic [1:0] ch, value_t v);
    voter_item_t it;
    it.cmd     = cmd;
    it.channel = ch;
    it.sample  = v;
    item_backlog.push_back(it);
  endfunction

  // ticks, writes, votes and reads; most writes cluster around base so the tolerance branches are hit
  function automatic voter_item_t random_item(value_t base, int unsigned spread);
    voter_item_t it;
    int unsigned pick;
    it.channel = ($urandom_range(19) == 0) ? ChanNone : 2'($urandom_range(2));
    it.sample  = value_t'($urandom);
    pick       = $urandom_range(99);
    if (pick < 25) begin
      it.cmd = CmdTick;
    end else if (pick < 60) begin
      it.cmd = CmdWrite;
      pick   = $urandom_range(9);
      if (pick < 6) it.sample = base + value_t'($urandom_range(spread));
      else if (pick == 6) it.sample = {1'b1, {(VW-1){1'b0}}};
      else if (pick == 7) it.sample = {1'b0, {(VW-1){1'b1}}};
    end else if (pick < 85) begin
      it.cmd = CmdVote;
    end else begin
      it.cmd = CmdRead;
    end
    return it;
  endfunction

  task automatic random_phase(int unsigned n_items, int unsigned tx_pct, int unsigned rx_pct,
                              value_t base, int unsigned spread);
    @(negedge clk_i);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) item_backlog.push_back(random_item(base, spread));
    drain();
  endtask

  // stimulus
  initial begin
    logic [30:0] tol_pick;
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    cfg_tol                = '0;
    cfg_use_low            = 1'b0;
    for (int c = 0; c < NumChan; c++) begin
      cfg_timeout[c] = '0;
      cfg_safe[c]    = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: every channel sits at its limit, then one tick takes every channel out of the vote
    push_item(CmdVote, ChanA, '0);
    push_item(CmdRead, ChanA, '0);
    push_item(CmdTick, ChanC, '1);
    push_item(CmdVote, ChanB, '0);
    drain();

    // directed: extremes, out-of-range channel, agreement levels, limit and staleness
    set_config(32'h0000_0100, 1'b0, 32'd2, 32'd2, 32'd2,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_8000);
    @(negedge clk_i);
    push_item(CmdWrite, ChanA, 32'sh7FFF_FFFF);
    push_item(CmdWrite, ChanB, 32'sh8000_0000);
    push_item(CmdWrite, ChanC, 32'sh0000_0000);
    push_item(CmdVote,  ChanA, '0);
    push_item(CmdRead,  ChanA, '0);
    push_item(CmdRead,  ChanC, '0);
    push_item(CmdWrite, ChanNone, 32'sh1234_5678);
    push_item(CmdRead,  ChanNone, '0);
    push_item(CmdWrite, ChanA, 32'sh0001_0000);
    push_item(CmdWrite, ChanB, 32'sh0001_0080);
    push_item(CmdWrite, ChanC, 32'sh0001_0100);
    push_item(CmdVote,  ChanA, '0);
    push_item(CmdWrite, ChanC, 32'sh0002_0000);
    push_item(CmdVote,  ChanA, '0);
    push_item(CmdTick,  ChanA, '0);
    push_item(CmdTick,  ChanB, '0);
    push_item(CmdVote,  ChanA, '0);
    push_item(CmdRead,  ChanB, '0);
    push_item(CmdTick,  ChanA, '0);
    push_item(CmdWrite, ChanB, 32'sh0000_1234);
    push_item(CmdVote,  ChanA, '0);
    push_item(CmdWrite, ChanA, 32'sh0000_5678);
    push_item(CmdVote,  ChanA, '0);
    drain();

    // random phases over several settings and idle patterns
    set_config(32'h0000_0200, 1'b0, 32'd3, 32'd4, 32'd5,
               -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    random_phase(150, 0, 0, value_t'($urandom), 32'h600);

    set_config(32'h0, 1'b1, 32'd0, 32'd1, 32'hFFFF_FFFF,
               value_t'($urandom), value_t'($urandom), value_t'($urandom));
    random_phase(140, 84, 0, value_t'($urandom), 2);

    set_config(32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    random_phase(140, 0, 84, value_t'($urandom), 32'hFFFF_FFFF);

    tol_pick = 31'($urandom_range(32'h1000));
    set_config({1'b0, tol_pick}, 1'b1, $urandom_range(6), $urandom_range(6),
               $urandom_range(6), value_t'($urandom), value_t'($urandom), value_t'($urandom));
    random_phase(140, 22, 22, value_t'($urandom), 3 * tol_pick + 1);

    // receiver holds off while the sender keeps offering, input backs up
    set_config(32'h0000_0100, 1'b0, 32'd2, 32'd2, 32'd2,
               32'sh0000_0000, -32'sd65536, 32'sh0001_0000);
    @(negedge clk_i);
    rx_hold_req = 1'b1;
    random_phase(150, 0, 0, value_t'($urandom), 32'h300);

    tol_pick = 31'($urandom);
    set_config({1'b0, tol_pick}, 1'($urandom), $urandom_range(8), $urandom_range(8),
               $urandom_range(8), value_t'($urandom), value_t'($urandom), value_t'($urandom));
    random_phase(120, 84, 84, value_t'($urandom), $urandom);

    set_config(32'h0000_0080, 1'b1, 32'd1, 32'd6, 32'd3,
               32'sh8000_0000, 32'sh0000_0000, -32'sd1);
    random_phase(150, 0, 0, value_t'($urandom), 32'h180);

    tol_pick = 31'($urandom_range(32'h4000));
    set_config({1'b0, tol_pick}, 1'b0, $urandom_range(4), $urandom_range(4),
               $urandom_range(4), value_t'($urandom), value_t'($urandom), value_t'($urandom));
    random_phase(110, 22, 22, value_t'($urandom), 3 * tol_pick + 1);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("stale_aware_triple_voter_core verification clean");
    end else begin
      $display("stale_aware_triple_voter_core verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("stale_aware_triple_voter_core verification failed");
    $finish;
  end

endmodule

/* stale_aware_triple_voter_core.f */
rtl/satv_pkg.sv
rtl/satv_if.sv
rtl/stale_aware_triple_voter_core.sv
dv/tb.sv
